// ----- rtl/ppc_pkg.sv -----
`timescale 1ns / 1ps
package ppc_pkg;

   localparam int NUM_KINDS = 20;
   localparam int FRAC_BITS = 16;
   localparam int MAX_LEN   = 65535;
   localparam int KIND_BITS = 5;
   localparam int CNT_W     = 16;
   localparam int PK_W      = 11;
   localparam int PH_W      = 7;
   localparam int H_W       = FRAC_BITS + 1;
   localparam int CHG_W     = 34;
   localparam int RPT_W     = 33;
   localparam int V_W       = 48;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int D_W       = V_W + Q_W;
   localparam int SC_W      = $clog2(Q_W + 1);
   localparam int WGT_W     = 31;
   localparam int ABS_W     = 29;
   localparam int MP_W      = 7;
   localparam int MREM_W    = 23;

   localparam logic [28:0]      TENTH_ROOT_Q28 = 29'd274688121;
   localparam logic [V_W-1:0]   Q28_ONE        = V_W'(64'd1 << 28);
   localparam logic [H_W-1:0]   H_ONE          = H_W'(64'd1 << FRAC_BITS);
   localparam logic [14:0]      WATER_CENTI    = 15'd1800;
   localparam logic [PH_W-1:0]  PH_MIN         = 7'd20;
   localparam logic [PH_W-1:0]  PH_MAX         = 7'd120;
   localparam logic [PH_W-1:0]  PH_RESET       = 7'd74;
   localparam logic [PH_W-1:0]  GRID_FIRST     = 7'd21;
   localparam logic [PH_W-1:0]  PI_BASE        = 7'd20;
   localparam logic [6:0]       LAST_Z         = 7'd99;
   localparam logic [10:0]      FAR_DELTA      = 11'd600;

   localparam logic [4:0] KIND_C    = 5'd1;
   localparam logic [4:0] KIND_D    = 5'd2;
   localparam logic [4:0] KIND_E    = 5'd3;
   localparam logic [4:0] KIND_H    = 5'd6;
   localparam logic [4:0] KIND_K    = 5'd8;
   localparam logic [4:0] KIND_M    = 5'd10;
   localparam logic [4:0] KIND_P    = 5'd12;
   localparam logic [4:0] KIND_R    = 5'd14;
   localparam logic [4:0] KIND_S    = 5'd15;
   localparam logic [4:0] KIND_T    = 5'd16;
   localparam logic [4:0] KIND_V    = 5'd17;
   localparam logic [4:0] KIND_W    = 5'd18;
   localparam logic [4:0] KIND_Y    = 5'd19;
   localparam logic [4:0] KIND_A    = 5'd0;
   localparam logic [4:0] KIND_LAST = 5'd19;

   localparam logic [3:0] GRP_C     = 4'd0;
   localparam logic [3:0] GRP_D     = 4'd1;
   localparam logic [3:0] GRP_E     = 4'd2;
   localparam logic [3:0] GRP_H     = 4'd3;
   localparam logic [3:0] GRP_K     = 4'd4;
   localparam logic [3:0] GRP_R     = 4'd5;
   localparam logic [3:0] GRP_Y     = 4'd6;
   localparam logic [3:0] GRP_NTERM = 4'd7;
   localparam logic [3:0] GRP_CTERM = 4'd8;

   localparam logic [2:0] MOLE_LAST_STEP = 3'd6;
   localparam logic       REG_REPORT_PH  = 1'b0;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_EV_CLR,
      ST_EV_GRP,
      ST_EV_WAIT,
      ST_EV_MUL,
      ST_EV_ACC,
      ST_EV_END,
      ST_ROW_DIV_LD,
      ST_ROW_DIV,
      ST_ROW_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_MUL,
      DP_TEN,
      DP_DIV,
      DP_FIN
   } dep_state_type;

   typedef struct packed {
      logic       load;
      logic       take;
      logic       clear_seq;
      logic       clear_res;
      logic       ev_clr;
      logic       dp_start;
      logic       mul;
      logic       acc;
      logic       save_report;
      logic       set_pi;
      logic       grid;
      logic [3:0] grp;
      logic [6:0] z;
      logic [4:0] kind;
      logic       div_load;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic seq_empty;
      logic grp_live;
      logic dp_done;
      logic charge_le0;
      logic out_free;
   } sts_type;

   function automatic logic [14:0] mass_centi(input logic [4:0] k);
      logic [14:0] m;
      unique case (k)
         5'd0:    m = 15'd8909;
         5'd1:    m = 15'd12112;
         5'd2:    m = 15'd13310;
         5'd3:    m = 15'd14713;
         5'd4:    m = 15'd16519;
         5'd5:    m = 15'd7507;
         5'd6:    m = 15'd15516;
         5'd7:    m = 15'd13117;
         5'd8:    m = 15'd14619;
         5'd9:    m = 15'd13117;
         5'd10:   m = 15'd14921;
         5'd11:   m = 15'd13210;
         5'd12:   m = 15'd11513;
         5'd13:   m = 15'd14615;
         5'd14:   m = 15'd17420;
         5'd15:   m = 15'd10509;
         5'd16:   m = 15'd11912;
         5'd17:   m = 15'd11715;
         5'd18:   m = 15'd20422;
         5'd19:   m = 15'd18119;
         default: m = 15'd0;
      endcase
      return m;
   endfunction

   function automatic logic [12:0] absorb_inc(input logic [4:0] k);
      logic [12:0] a;
      a = 13'd0;
      if (k == KIND_W) begin
         a = 13'd5500;
      end else if (k == KIND_Y) begin
         a = 13'd1490;
      end else if (k == KIND_C) begin
         a = 13'd63;
      end
      return a;
   endfunction

   function automatic logic [4:0] grp_kind(input logic [3:0] g);
      logic [4:0] k;
      unique case (g)
         GRP_C:   k = KIND_C;
         GRP_D:   k = KIND_D;
         GRP_E:   k = KIND_E;
         GRP_H:   k = KIND_H;
         GRP_K:   k = KIND_K;
         GRP_R:   k = KIND_R;
         GRP_Y:   k = KIND_Y;
         default: k = KIND_A;
      endcase
      return k;
   endfunction

   function automatic logic [PK_W-1:0] side_pk(input logic [3:0] g);
      logic [PK_W-1:0] p;
      unique case (g)
         GRP_C:   p = 11'd900;
         GRP_D:   p = 11'd405;
         GRP_E:   p = 11'd445;
         GRP_H:   p = 11'd598;
         GRP_K:   p = 11'd1000;
         GRP_R:   p = 11'd1200;
         GRP_Y:   p = 11'd1000;
         default: p = 11'd0;
      endcase
      return p;
   endfunction

   function automatic logic [PK_W-1:0] nterm_pk(input logic [4:0] k);
      logic [PK_W-1:0] p;
      unique case (k)
         KIND_A:  p = 11'd759;
         KIND_E:  p = 11'd770;
         KIND_M:  p = 11'd700;
         KIND_P:  p = 11'd836;
         KIND_S:  p = 11'd693;
         KIND_T:  p = 11'd682;
         KIND_V:  p = 11'd744;
         default: p = 11'd750;
      endcase
      return p;
   endfunction

   function automatic logic [PK_W-1:0] cterm_pk(input logic [4:0] k);
      logic [PK_W-1:0] p;
      unique case (k)
         KIND_D:  p = 11'd455;
         KIND_E:  p = 11'd475;
         default: p = 11'd355;
      endcase
      return p;
   endfunction

   function automatic logic grp_basic(input logic [3:0] g);
      return (g == GRP_H) || (g == GRP_K) || (g == GRP_R) || (g == GRP_NTERM);
   endfunction

endpackage

// ----- rtl/protein_property_calculator_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_residue, req_last
// rsp       out        rsp_valid/rsp_ready    kind, count, mole percent, weight, charge, pI
// csr       in/out     psel/penable/pready    paddr, pwdata, prdata (report pH)
//
// Residues are taken one per cycle while a sequence loads.
// After the final item, each charge group present runs a shared multiply chain and
// a restoring divider; up to nine groups run per pH point and up to 101 points
// are visited, then each of the 20 rows runs a mole-percent division and is sent.
// Reset is synchronous and clears all counts and control state.
// A stalled rsp channel holds the current row; the next row waits for it.
module protein_property_calculator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_residue,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_kind_index,
   output logic [15:0]        rsp_kind_count,
   output logic [6:0]         rsp_mole_percent,
   output logic [30:0]        rsp_weight_centi,
   output logic [28:0]        rsp_absorptivity,
   output logic signed [32:0] rsp_charge_at_ph,
   output logic [6:0]         rsp_pi_tenths,
   output logic               rsp_pi_found,
   output logic               rsp_final_row,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   ppc_pkg::cmd_type cmd;
   ppc_pkg::sts_type sts;

   ppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   ppc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .sts_o            (sts),
      .req_residue      (req_residue),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind_index   (rsp_kind_index),
      .rsp_kind_count   (rsp_kind_count),
      .rsp_mole_percent (rsp_mole_percent),
      .rsp_weight_centi (rsp_weight_centi),
      .rsp_absorptivity (rsp_absorptivity),
      .rsp_charge_at_ph (rsp_charge_at_ph),
      .rsp_pi_tenths    (rsp_pi_tenths),
      .rsp_pi_found     (rsp_pi_found),
      .rsp_final_row    (rsp_final_row)
   );

endmodule

// ----- rtl/ppc_deprot.sv -----
`timescale 1ns / 1ps
module ppc_deprot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ppc_pkg::PK_W-1:0]  pk,
   input  logic [ppc_pkg::PH_W-1:0]  ph,
   output logic                      done,
   output logic [ppc_pkg::H_W-1:0]   h
);

   ppc_pkg::dep_state_type       state_ff, state_in;
   logic [ppc_pkg::V_W-1:0]      v_ff, v_in;
   logic [6:0]                   mcnt_ff, mcnt_in;
   logic [2:0]                   tcnt_ff, tcnt_in;
   logic [ppc_pkg::D_W-1:0]      rem_ff, rem_in;
   logic [ppc_pkg::D_W-1:0]      dsh_ff, dsh_in;
   logic [ppc_pkg::Q_W-1:0]      quo_ff, quo_in;
   logic [ppc_pkg::SC_W-1:0]     scnt_ff, scnt_in;
   logic                         neg_ff, neg_in;

   logic [10:0]                  ph_x10;
   logic signed [11:0]           delta;
   logic [10:0]                  mag;
   logic [2:0]                   hund;
   logic [10:0]                  hund_val;
   logic [6:0]                   frac;
   logic [60:0]                  prod;
   logic [ppc_pkg::V_W-1:0]      vt;
   logic                         ge;

   assign ph_x10   = ({4'd0, ph} << 3) + ({4'd0, ph} << 1);
   assign delta    = $signed({1'b0, pk}) - $signed({1'b0, ph_x10});
   assign mag      = delta[11] ? 11'(-delta) : delta[10:0];
   assign prod     = 61'(v_ff[31:0]) * 61'(ppc_pkg::TENTH_ROOT_Q28);
   assign vt       = v_ff + ppc_pkg::Q28_ONE;
   assign ge       = rem_ff >= dsh_ff;
   assign frac     = 7'(mag - hund_val);

   always_comb begin
      if (mag >= 11'd500) begin
         hund = 3'd5;
      end else if (mag >= 11'd400) begin
         hund = 3'd4;
      end else if (mag >= 11'd300) begin
         hund = 3'd3;
      end else if (mag >= 11'd200) begin
         hund = 3'd2;
      end else if (mag >= 11'd100) begin
         hund = 3'd1;
      end else begin
         hund = 3'd0;
      end
      hund_val = ({8'd0, hund} << 6) + ({8'd0, hund} << 5) + ({8'd0, hund} << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppc_pkg::DP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      mcnt_ff <= mcnt_in;
      tcnt_ff <= tcnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      scnt_ff <= scnt_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      mcnt_in  = mcnt_ff;
      tcnt_in  = tcnt_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      scnt_in  = scnt_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         ppc_pkg::DP_IDLE: begin
            if (start) begin
               neg_in = delta[11];
               if (mag >= ppc_pkg::FAR_DELTA) begin
                  quo_in   = '0;
                  state_in = ppc_pkg::DP_FIN;
               end else begin
                  v_in     = ppc_pkg::Q28_ONE;
                  mcnt_in  = frac;
                  tcnt_in  = hund;
                  state_in = ppc_pkg::DP_MUL;
               end
            end
         end
         ppc_pkg::DP_MUL: begin
            if (mcnt_ff == 7'd0) begin
               state_in = ppc_pkg::DP_TEN;
            end else begin
               v_in    = ppc_pkg::V_W'(prod[59:28]);
               mcnt_in = mcnt_ff - 7'd1;
            end
         end
         ppc_pkg::DP_TEN: begin
            if (tcnt_ff == 3'd0) begin
               rem_in   = (ppc_pkg::D_W'(1) << (28 + ppc_pkg::FRAC_BITS))
                          + ppc_pkg::D_W'(vt >> 1);
               dsh_in   = ppc_pkg::D_W'(vt) << (ppc_pkg::Q_W - 1);
               quo_in   = '0;
               scnt_in  = ppc_pkg::SC_W'(ppc_pkg::Q_W);
               state_in = ppc_pkg::DP_DIV;
            end else begin
               v_in    = (v_ff << 3) + (v_ff << 1);
               tcnt_in = tcnt_ff - 3'd1;
            end
         end
         ppc_pkg::DP_DIV: begin
            rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
            quo_in  = {quo_ff[ppc_pkg::Q_W-2:0], ge};
            dsh_in  = dsh_ff >> 1;
            scnt_in = scnt_ff - ppc_pkg::SC_W'(1);
            if (scnt_ff == ppc_pkg::SC_W'(1)) begin
               state_in = ppc_pkg::DP_FIN;
            end
         end
         ppc_pkg::DP_FIN: begin
            state_in = ppc_pkg::DP_IDLE;
         end
         default: begin
            state_in = ppc_pkg::DP_IDLE;
         end
      endcase
   end

   assign done = state_ff == ppc_pkg::DP_FIN;
   assign h    = neg_ff ? ppc_pkg::H_ONE - quo_ff : quo_ff;

endmodule

// ----- rtl/ppc_dpath.sv -----
`timescale 1ns / 1ps
module ppc_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  ppc_pkg::cmd_type               cmd_i,
   output ppc_pkg::sts_type               sts_o,
   input  logic [4:0]                     req_residue,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [4:0]                     rsp_kind_index,
   output logic [15:0]                    rsp_kind_count,
   output logic [6:0]                     rsp_mole_percent,
   output logic [30:0]                    rsp_weight_centi,
   output logic [28:0]                    rsp_absorptivity,
   output logic signed [32:0]             rsp_charge_at_ph,
   output logic [6:0]                     rsp_pi_tenths,
   output logic                           rsp_pi_found,
   output logic                           rsp_final_row
);

   localparam int PROD_W = ppc_pkg::H_W + ppc_pkg::CNT_W + 2;

   logic [ppc_pkg::CNT_W-1:0]     cnt_ff [ppc_pkg::NUM_KINDS];
   logic [ppc_pkg::CNT_W-1:0]     len_ff;
   logic [4:0]                    first_ff;
   logic [4:0]                    last_ff;
   logic [ppc_pkg::WGT_W-1:0]     wacc_ff;
   logic [ppc_pkg::ABS_W-1:0]     aacc_ff;
   logic [ppc_pkg::PH_W-1:0]      rep_ff;
   logic [ppc_pkg::H_W-1:0]       h_ff;
   logic signed [ppc_pkg::CHG_W-1:0] contrib_ff;
   logic signed [ppc_pkg::CHG_W-1:0] chg_ff;
   logic [ppc_pkg::RPT_W-1:0]     chgrep_ff;
   logic [ppc_pkg::PH_W-1:0]      pi_ff;
   logic                          found_ff;
   logic [ppc_pkg::MREM_W-1:0]    mrem_ff;
   logic [ppc_pkg::MREM_W-1:0]    mdsh_ff;
   logic [ppc_pkg::MP_W-1:0]      mquo_ff;
   logic                          rsp_valid_ff;

   logic [4:0]                    rd_kind;
   logic [ppc_pkg::CNT_W-1:0]     rd_cnt;
   logic                          keep;
   logic [1:0]                    dec;
   logic [ppc_pkg::CNT_W-1:0]     internal;
   logic                          term;
   logic [ppc_pkg::PH_W-1:0]      ph_rep;
   logic [ppc_pkg::PH_W-1:0]      ph;
   logic [ppc_pkg::PK_W-1:0]      pk;
   logic                          dp_done;
   logic [ppc_pkg::H_W-1:0]       dp_h;
   logic signed [ppc_pkg::H_W:0]  cval;
   logic [ppc_pkg::CNT_W-1:0]     cntv;
   logic signed [PROD_W-1:0]      prod;
   logic                          mge;
   logic                          empty;
   logic                          reg_hit;

   assign rd_kind = cmd_i.load ? req_residue : cmd_i.kind;
   assign rd_cnt  = (rd_kind < 5'(ppc_pkg::NUM_KINDS)) ? cnt_ff[rd_kind] : '0;
   assign keep    = cmd_i.take && (req_residue < 5'(ppc_pkg::NUM_KINDS))
                    && (len_ff < ppc_pkg::CNT_W'(ppc_pkg::MAX_LEN));
   assign empty   = len_ff == '0;

   always_ff @(posedge clock) begin
      if (reset || cmd_i.clear_seq) begin
         for (int i = 0; i < ppc_pkg::NUM_KINDS; i++) begin
            cnt_ff[i] <= '0;
         end
         len_ff   <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         wacc_ff  <= '0;
         aacc_ff  <= '0;
      end else if (keep) begin
         cnt_ff[req_residue] <= rd_cnt + ppc_pkg::CNT_W'(1);
         len_ff              <= len_ff + ppc_pkg::CNT_W'(1);
         if (empty) begin
            first_ff <= req_residue;
         end
         last_ff <= req_residue;
         wacc_ff <= wacc_ff + ppc_pkg::WGT_W'(ppc_pkg::mass_centi(req_residue)
                                              - ppc_pkg::WATER_CENTI);
         aacc_ff <= aacc_ff + ppc_pkg::ABS_W'(ppc_pkg::absorb_inc(req_residue));
      end
   end

   assign reg_hit = paddr[2] == ppc_pkg::REG_REPORT_PH;
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {25'd0, rep_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff <= ppc_pkg::PH_RESET;
      end else if (psel && penable && pwrite && reg_hit) begin
         rep_ff <= pwdata[6:0];
      end
   end

   assign dec      = 2'(cmd_i.kind == first_ff) + 2'(cmd_i.kind == last_ff);
   assign internal = (rd_cnt > ppc_pkg::CNT_W'(dec)) ? rd_cnt - ppc_pkg::CNT_W'(dec) : '0;
   assign term     = cmd_i.grp >= ppc_pkg::GRP_NTERM;

   assign ph_rep = (rep_ff < ppc_pkg::PH_MIN) ? ppc_pkg::PH_MIN :
                   ((rep_ff > ppc_pkg::PH_MAX) ? ppc_pkg::PH_MAX : rep_ff);
   assign ph     = cmd_i.grid ? cmd_i.z + ppc_pkg::GRID_FIRST : ph_rep;

   always_comb begin
      priority if (cmd_i.grp == ppc_pkg::GRP_NTERM) begin
         pk = ppc_pkg::nterm_pk(first_ff);
      end else if (cmd_i.grp == ppc_pkg::GRP_CTERM) begin
         pk = ppc_pkg::cterm_pk(last_ff);
      end else begin
         pk = ppc_pkg::side_pk(cmd_i.grp);
      end
   end

   ppc_deprot u_deprot (
      .clock (clock),
      .reset (reset),
      .start (cmd_i.dp_start),
      .pk    (pk),
      .ph    (ph),
      .done  (dp_done),
      .h     (dp_h)
   );

   assign cval = ppc_pkg::grp_basic(cmd_i.grp)
                 ? $signed({1'b0, ppc_pkg::H_ONE - h_ff})
                 : -$signed({1'b0, h_ff});
   assign cntv = term ? ppc_pkg::CNT_W'(1) : internal;
   assign prod = cval * $signed({1'b0, cntv});

   always_ff @(posedge clock) begin
      if (dp_done) begin
         h_ff <= dp_h;
      end
      if (cmd_i.mul) begin
         contrib_ff <= prod[ppc_pkg::CHG_W-1:0];
      end
      if (cmd_i.ev_clr) begin
         chg_ff <= '0;
      end else if (cmd_i.acc) begin
         chg_ff <= chg_ff + contrib_ff;
      end
      if (cmd_i.clear_res) begin
         chgrep_ff <= '0;
         pi_ff     <= '0;
         found_ff  <= 1'b0;
      end else begin
         if (cmd_i.save_report) begin
            chgrep_ff <= chg_ff[ppc_pkg::RPT_W-1:0];
         end
         if (cmd_i.set_pi) begin
            pi_ff    <= cmd_i.z + ppc_pkg::PI_BASE;
            found_ff <= 1'b1;
         end
      end
   end

   assign mge = mrem_ff >= mdsh_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.div_load) begin
         mrem_ff <= ({7'd0, rd_cnt} << 6) + ({7'd0, rd_cnt} << 5) + ({7'd0, rd_cnt} << 2);
         mdsh_ff <= {1'b0, len_ff, 6'd0};
         mquo_ff <= '0;
      end else if (cmd_i.div_step) begin
         mrem_ff <= mge ? mrem_ff - mdsh_ff : mrem_ff;
         mdsh_ff <= mdsh_ff >> 1;
         mquo_ff <= {mquo_ff[ppc_pkg::MP_W-2:0], mge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         rsp_kind_index   <= cmd_i.kind;
         rsp_kind_count   <= rd_cnt;
         rsp_mole_percent <= empty ? '0 : mquo_ff;
         rsp_weight_centi <= empty ? '0 : wacc_ff + ppc_pkg::WGT_W'(ppc_pkg::WATER_CENTI);
         rsp_absorptivity <= aacc_ff;
         rsp_charge_at_ph <= chgrep_ff;
         rsp_pi_tenths    <= pi_ff;
         rsp_pi_found     <= found_ff;
         rsp_final_row    <= cmd_i.kind == ppc_pkg::KIND_LAST;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign sts_o.seq_empty   = empty;
   assign sts_o.grp_live    = term || (internal != '0);
   assign sts_o.dp_done     = dp_done;
   assign sts_o.charge_le0  = chg_ff[ppc_pkg::CHG_W-1] || (chg_ff == '0);
   assign sts_o.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

// ----- rtl/ppc_ctrl.sv -----
`timescale 1ns / 1ps
module ppc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   input  ppc_pkg::sts_type  sts_i,
   output ppc_pkg::cmd_type  cmd_o
);

   ppc_pkg::ctrl_state_type state_ff, state_in;
   logic [3:0]              grp_ff, grp_in;
   logic [6:0]              z_ff, z_in;
   logic                    grid_ff, grid_in;
   logic [4:0]              row_ff, row_in;
   logic [2:0]              dstep_ff, dstep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppc_pkg::ST_LOAD;
         grp_ff   <= '0;
         z_ff     <= '0;
         grid_ff  <= 1'b0;
         row_ff   <= '0;
         dstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         z_ff     <= z_in;
         grid_ff  <= grid_in;
         row_ff   <= row_in;
         dstep_ff <= dstep_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      grp_in     = grp_ff;
      z_in       = z_ff;
      grid_in    = grid_ff;
      row_in     = row_ff;
      dstep_in   = dstep_ff;
      cmd_o      = '0;
      cmd_o.grp  = grp_ff;
      cmd_o.z    = z_ff;
      cmd_o.grid = grid_ff;
      cmd_o.kind = ppc_pkg::grp_kind(grp_ff);
      unique case (state_ff)
         ppc_pkg::ST_LOAD: begin
            cmd_o.load = 1'b1;
            cmd_o.take = req_valid;
            if (req_valid && req_last) begin
               state_in = ppc_pkg::ST_CHECK;
            end
         end
         ppc_pkg::ST_CHECK: begin
            cmd_o.clear_res = 1'b1;
            row_in          = '0;
            grid_in         = 1'b0;
            z_in            = '0;
            state_in        = sts_i.seq_empty ? ppc_pkg::ST_ROW_DIV_LD : ppc_pkg::ST_EV_CLR;
         end
         ppc_pkg::ST_EV_CLR: begin
            cmd_o.ev_clr = 1'b1;
            grp_in       = '0;
            state_in     = ppc_pkg::ST_EV_GRP;
         end
         ppc_pkg::ST_EV_GRP: begin
            if (sts_i.grp_live) begin
               cmd_o.dp_start = 1'b1;
               state_in       = ppc_pkg::ST_EV_WAIT;
            end else begin
               grp_in = grp_ff + 4'd1;
            end
         end
         ppc_pkg::ST_EV_WAIT: begin
            if (sts_i.dp_done) begin
               state_in = ppc_pkg::ST_EV_MUL;
            end
         end
         ppc_pkg::ST_EV_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = ppc_pkg::ST_EV_ACC;
         end
         ppc_pkg::ST_EV_ACC: begin
            cmd_o.acc = 1'b1;
            if (grp_ff == ppc_pkg::GRP_CTERM) begin
               state_in = ppc_pkg::ST_EV_END;
            end else begin
               grp_in   = grp_ff + 4'd1;
               state_in = ppc_pkg::ST_EV_GRP;
            end
         end
         ppc_pkg::ST_EV_END: begin
            priority if (!grid_ff) begin
               cmd_o.save_report = 1'b1;
               grid_in           = 1'b1;
               z_in              = '0;
               state_in          = ppc_pkg::ST_EV_CLR;
            end else if (sts_i.charge_le0) begin
               cmd_o.set_pi = 1'b1;
               row_in       = '0;
               state_in     = ppc_pkg::ST_ROW_DIV_LD;
            end else if (z_ff == ppc_pkg::LAST_Z) begin
               row_in   = '0;
               state_in = ppc_pkg::ST_ROW_DIV_LD;
            end else begin
               z_in     = z_ff + 7'd1;
               state_in = ppc_pkg::ST_EV_CLR;
            end
         end
         ppc_pkg::ST_ROW_DIV_LD: begin
            cmd_o.kind     = row_ff;
            cmd_o.div_load = 1'b1;
            dstep_in       = '0;
            state_in       = ppc_pkg::ST_ROW_DIV;
         end
         ppc_pkg::ST_ROW_DIV: begin
            cmd_o.kind     = row_ff;
            cmd_o.div_step = 1'b1;
            dstep_in       = dstep_ff + 3'd1;
            if (dstep_ff == ppc_pkg::MOLE_LAST_STEP) begin
               state_in = ppc_pkg::ST_ROW_OUT;
            end
         end
         ppc_pkg::ST_ROW_OUT: begin
            cmd_o.kind = row_ff;
            if (sts_i.out_free) begin
               cmd_o.out_load = 1'b1;
               if (row_ff == ppc_pkg::KIND_LAST) begin
                  cmd_o.clear_seq = 1'b1;
                  state_in        = ppc_pkg::ST_LOAD;
               end else begin
                  row_in   = row_ff + 5'd1;
                  state_in = ppc_pkg::ST_ROW_DIV_LD;
               end
            end
         end
         default: begin
            state_in = ppc_pkg::ST_LOAD;
         end
      endcase
   end

   assign req_ready = cmd_o.load;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd_o.clear_seq |=> sts_i.seq_empty)
      else $error("Sequence state was not cleared after the final row.");

   assert property (@(posedge clock) disable iff (reset)
      grp_ff <= ppc_pkg::GRP_CTERM)
      else $error("Charge group index ran past the C-terminus.");

   assert property (@(posedge clock) disable iff (reset)
      z_ff <= ppc_pkg::LAST_Z)
      else $error("Grid index ran past the last pH point.");

   assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (row_ff <= ppc_pkg::KIND_LAST) && sts_i.out_free)
      else $error("Result row loaded out of range or over a pending item.");
`endif

endmodule
